/* hdl/quadrature_angle_speed_estimator_unit_macros.svh */
// ============================================================================
// Assertion macros for the quadrature angle and speed estimator
// Short forms of the concurrent assertions used by the port checker.
// ============================================================================
`ifndef QUADRATURE_ANGLE_SPEED_ESTIMATOR_UNIT_MACROS_SVH
`define QUADRATURE_ANGLE_SPEED_ESTIMATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QASE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QASE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/qase_pkg.sv */
// ============================================================================
// qase_pkg
// Types, widths and constants shared by the estimator modules.
// ============================================================================
package qase_pkg;

    localparam int RAW_W      = 16;
    localparam int POS_W      = 17;
    localparam int ANGLE_W    = 16;
    localparam int CPR_W      = 16;
    localparam int PP_W       = 7;
    localparam int PERIOD_W   = 16;
    localparam int WINDOW_W   = 8;
    localparam int SCALE_W    = 32;
    localparam int SPEED_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_WINDOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE     = 3'd5;

    // Register values after reset
    localparam logic [RAW_W-1:0]    RST_POSITION_OFFSET = 16'd0;
    localparam logic [CPR_W-1:0]    RST_COUNTS_PER_REV  = 16'd4000;
    localparam logic [PP_W-1:0]     RST_POLE_PAIRS      = 7'd4;
    localparam logic [PERIOD_W-1:0] RST_COUNTER_PERIOD  = 16'd64000;
    localparam logic [WINDOW_W-1:0] RST_SPEED_WINDOW    = 8'd10;
    localparam logic [SCALE_W-1:0]  RST_SPEED_SCALE     = 32'd1966080;

    // pi/30 in Q28, rpm to rad/s
    localparam logic [24:0] PI30_Q28 = 25'd28110495;

    typedef struct packed {
        logic [RAW_W-1:0] raw_count;
        logic             counting_down;
    } t_in_item;

    typedef struct packed {
        logic [ANGLE_W-1:0]        electrical_angle;
        logic signed [SPEED_W-1:0] speed_rpm;
        logic signed [SPEED_W-1:0] electrical_speed;
        logic                      speed_updated;
    } t_out_item;

    typedef struct packed {
        logic                    start;
        logic signed [POS_W-1:0] value;
        logic [CPR_W-1:0]        cpr;
        logic [PP_W-1:0]         pp;
    } t_angle_req;

    typedef struct packed {
        logic               busy;
        logic [ANGLE_W-1:0] angle;
    } t_angle_rsp;

    // Quotient of an 8-bit value below 160 by ten, by reciprocal multiplication.
    function automatic logic [3:0] qase_div10_q(input logic [7:0] t);
        logic [18:0] p;
        p = 19'(t) * 19'd205;
        return p[14:11];
    endfunction

endpackage

/* hdl/qase_angle.sv */
// ============================================================================
// qase_angle
// Bit-serial electrical angle unit: wraps the position into one revolution by
// restoring division, then forms the angle as a 16-bit fraction of a turn.
// ============================================================================
module qase_angle (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qase_pkg::t_angle_req i_req,
    output qase_pkg::t_angle_rsp o_rsp
);
    import qase_pkg::*;

    localparam int MOD_STEPS = CPR_W;
    localparam int SH_W      = CPR_W + PP_W + ANGLE_W;
    localparam int CNT_W     = $clog2(SH_W);

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_MOD  = 5'b00010,
        A_FIX  = 5'b00100,
        A_MUL  = 5'b01000,
        A_DIV  = 5'b10000
    } t_ang_state;

    t_ang_state r_state, n_state;

    logic [SH_W-1:0]        r_sh;
    logic [CPR_W-1:0]       r_rem;
    logic [ANGLE_W-1:0]     r_quo;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_neg;
    logic [CPR_W-1:0]       r_pos;
    logic [ANGLE_W-1:0]     r_angle;

    logic [CPR_W-1:0]       w_mag;
    logic [CPR_W:0]         w_trial;
    logic                   w_ge;
    logic [CPR_W+PP_W-1:0]  w_prod;
    logic                   w_mod_last;
    logic                   w_div_last;

    always_comb begin
        w_mag      = i_req.value[POS_W-1] ? CPR_W'(-i_req.value) : i_req.value[CPR_W-1:0];
        w_trial    = {r_rem, r_sh[SH_W-1]};
        w_ge       = (w_trial >= {1'b0, i_req.cpr});
        w_prod     = (CPR_W+PP_W)'(r_pos) * (CPR_W+PP_W)'(i_req.pp);
        w_mod_last = (r_cnt == CNT_W'(MOD_STEPS - 1));
        w_div_last = (r_cnt == CNT_W'(SH_W - 1));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            A_IDLE: if (i_req.start) n_state = A_MOD;
            A_MOD:  if (w_mod_last) n_state = A_FIX;
            A_FIX:  n_state = A_MUL;
            A_MUL:  n_state = A_DIV;
            A_DIV:  if (w_div_last) n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            A_IDLE: begin
                r_sh  <= {w_mag, {(SH_W-CPR_W){1'b0}}};
                r_neg <= i_req.value[POS_W-1];
                r_rem <= '0;
                r_cnt <= '0;
            end
            A_MOD, A_DIV: begin
                // One restoring step: shift a dividend bit in, subtract if it fits.
                r_rem <= w_ge ? CPR_W'(w_trial - {1'b0, i_req.cpr}) : w_trial[CPR_W-1:0];
                r_sh  <= {r_sh[SH_W-2:0], 1'b0};
                r_quo <= {r_quo[ANGLE_W-2:0], w_ge};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_state == A_DIV && w_div_last) begin
                    r_angle <= (i_req.cpr == '0) ? '0 : {r_quo[ANGLE_W-2:0], w_ge};
                end
            end
            A_FIX: begin
                // A negative position with a remainder wraps up into the revolution.
                r_pos <= (r_neg && r_rem != '0) ? i_req.cpr - r_rem : r_rem;
            end
            A_MUL: begin
                r_sh  <= {w_prod, {ANGLE_W{1'b0}}};
                r_rem <= '0;
                r_cnt <= '0;
            end
            default: ;
        endcase
    end

    assign o_rsp.busy  = (r_state != A_IDLE);
    assign o_rsp.angle = r_angle;

endmodule

/* hdl/quadrature_angle_speed_estimator_unit.sv */
// ============================================================================
// quadrature_angle_speed_estimator_unit
// Angle and speed estimator for an incremental quadrature encoder.
//
// One input transfer per control tick carries the counter reading and its
// direction; each one yields exactly one result transfer with the electrical
// angle, the filtered rpm, the electrical speed and a window-complete flag.
// Both channels use valid and stall; the configuration port takes a register
// write whenever its valid is high, as ready is always high. Registers must be
// written only while no tick is in flight; the block does not enforce this.
// The bit-serial angle divider sets the pace: 16 steps for the revolution wrap
// and 39 for the fraction of a turn. The speed update (digit-serial multiply,
// divide by ten, scaling by pi/30) runs alongside it. A new tick is taken
// only once the previous one has finished. A result waits in the output
// register while the receiver stalls; the next tick is still taken and held
// back only when it finishes before that transfer. Reset restores the register
// defaults and clears the control and estimator state.
// ============================================================================
module quadrature_angle_speed_estimator_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  qase_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output qase_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qase_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [qase_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import qase_pkg::*;

    localparam int MASK_BITS = (COUNT_BITS < RAW_W) ? COUNT_BITS : RAW_W;
    localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((33'd1 << MASK_BITS) - 33'd1);

    localparam int MUL_DIGITS = SCALE_W / 4;
    localparam int DIV_DIGITS = 11;
    localparam int K_DIGITS   = 7;
    localparam logic [40:0] PROD_CAP = 41'(1) << 40;
    localparam logic [60:0] ELEC_CAP = 61'(1) << 60;
    localparam logic [60:0] RND_HALF = 61'(1) << 27;
    localparam logic [43:0] Q_POS_MAX = 44'h0007FFFFFFF;
    localparam logic [43:0] Q_NEG_MAX = 44'h00080000000;
    localparam logic [32:0] T_POS_MAX = 33'h07FFFFFFF;
    localparam logic [32:0] T_NEG_MAX = 33'h080000000;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PREP = 3'b010,
        ST_RUN  = 3'b100
    } t_state;

    typedef enum logic [9:0] {
        SP_IDLE = 10'b0000000001,
        SP_LOAD = 10'b0000000010,
        SP_MUL  = 10'b0000000100,
        SP_SUM  = 10'b0000001000,
        SP_COMB = 10'b0000010000,
        SP_MAG  = 10'b0000100000,
        SP_DIV  = 10'b0001000000,
        SP_SAT  = 10'b0010000000,
        SP_PP   = 10'b0100000000,
        SP_K    = 10'b1000000000
    } t_sp_state;

    t_state    r_state, n_state;
    t_sp_state r_sp_state, n_sp_state;
    logic      r_rnd_pending;

    // Configuration registers
    logic [RAW_W-1:0]    r_cfg_offset;
    logic [CPR_W-1:0]    r_cfg_cpr;
    logic [PP_W-1:0]     r_cfg_pp;
    logic [PERIOD_W-1:0] r_cfg_period;
    logic [WINDOW_W-1:0] r_cfg_window;
    logic [SCALE_W-1:0]  r_cfg_scale;

    // Estimator state
    logic signed [POS_W-1:0]   r_last_pos;
    logic signed [31:0]        r_acc;
    logic [WINDOW_W-1:0]       r_tick;
    logic signed [SPEED_W-1:0] r_filtered;
    logic signed [SPEED_W-1:0] r_held_elec;

    // Current tick
    logic signed [POS_W-1:0] r_value;
    logic                    r_down;
    logic                    r_upd;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    // Speed datapath
    logic [3:0]          r_sp_cnt;
    logic signed [31:0]  r_sp_acc;
    logic [31:0]         r_mul_m;
    logic                r_mul_neg;
    logic [SCALE_W-1:0]  r_scale_sh;
    logic [40:0]         r_prod;
    logic [42:0]         r_tp;
    logic signed [34:0]  r_sf;
    logic signed [44:0]  r_num;
    logic                r_num_neg;
    logic [43:0]         r_div_sh;
    logic [3:0]          r_rem;
    logic [43:0]         r_quo;
    logic [31:0]         r_e_m;
    logic                r_e_neg;
    logic [38:0]         r_e_mp;
    logic [27:0]         r_k_sh;
    logic [60:0]         r_e_prod;

    t_angle_req ang_req;
    t_angle_rsp ang_rsp;

    logic [RAW_W-1:0]     w_raw;
    logic signed [18:0]   w_value_x, w_last_x, w_period_x, w_delta;
    logic signed [32:0]   w_acc_sum;
    logic signed [31:0]   w_acc_sat;
    logic [WINDOW_W-1:0]  w_tick_next;
    logic                 w_upd;
    logic [35:0]          w_mul_pp;
    logic [44:0]          w_mul_sum;
    logic signed [34:0]   w_f35;
    logic [43:0]          w_num_mag;
    logic [7:0]           w_div_t;
    logic [3:0]           w_div_q;
    logic [7:0]           w_div_r;
    logic [31:0]          w_sat_mag;
    logic [42:0]          w_k_pp;
    logic [64:0]          w_k_sum;
    logic [60:0]          w_rnd_sum;
    logic [32:0]          w_t;
    logic [31:0]          w_e_mag;
    logic                 w_out_free;
    logic                 w_finish;

    always_comb begin
        w_raw      = i_in_data.raw_count & RAW_MASK;
        w_value_x  = {{2{r_value[POS_W-1]}}, r_value};
        w_last_x   = {{2{r_last_pos[POS_W-1]}}, r_last_pos};
        w_period_x = {3'b000, r_cfg_period};
        w_delta    = w_value_x - w_last_x;
        // Correct for the counter wrapping in the direction of travel.
        if (!r_down && (r_value < r_last_pos)) begin
            w_delta = w_delta + w_period_x;
        end else if (r_down && (r_value > r_last_pos)) begin
            w_delta = w_delta - w_period_x;
        end
        w_acc_sum = {r_acc[31], r_acc} + {{14{w_delta[18]}}, w_delta};
        if (w_acc_sum[32] != w_acc_sum[31]) begin
            w_acc_sat = w_acc_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            w_acc_sat = w_acc_sum[31:0];
        end
        w_tick_next = r_tick + WINDOW_W'(1);
        w_upd       = (w_tick_next >= r_cfg_window);

        w_mul_pp  = 36'(r_mul_m) * 36'(r_scale_sh[SCALE_W-1 -: 4]);
        w_mul_sum = {r_prod, 4'b0000} + 45'(w_mul_pp);
        w_f35     = {{3{r_filtered[31]}}, r_filtered};
        w_num_mag = r_num[44] ? 44'(-r_num) : r_num[43:0];

        w_div_t = {r_rem, r_div_sh[43:40]};
        w_div_q = qase_div10_q(w_div_t);
        w_div_r = w_div_t - 8'({w_div_q, 3'b000}) - 8'({w_div_q, 1'b0});

        if (r_num_neg) begin
            w_sat_mag = (r_quo > Q_NEG_MAX) ? 32'h80000000 : r_quo[31:0];
        end else begin
            w_sat_mag = (r_quo > Q_POS_MAX) ? 32'h7FFFFFFF : r_quo[31:0];
        end

        w_k_pp    = 43'(r_e_mp) * 43'(r_k_sh[27:24]);
        w_k_sum   = {r_e_prod, 4'b0000} + 65'(w_k_pp);
        w_rnd_sum = r_e_prod + RND_HALF;
        w_t       = w_rnd_sum[60:28];
        if (r_e_neg) begin
            w_e_mag = (w_t > T_NEG_MAX) ? 32'h80000000 : w_t[31:0];
        end else begin
            w_e_mag = (w_t > T_POS_MAX) ? 32'h7FFFFFFF : w_t[31:0];
        end

        w_out_free = !r_out_valid || !i_out_stall;
        w_finish   = (r_state == ST_RUN) && !ang_rsp.busy && (r_sp_state == SP_IDLE)
                     && !r_rnd_pending && w_out_free;
    end

    always_comb begin
        ang_req.start = (r_state == ST_PREP);
        ang_req.value = r_value;
        ang_req.cpr   = r_cfg_cpr;
        ang_req.pp    = r_cfg_pp;
    end

    qase_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ang_req),
        .o_rsp   (ang_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_PREP;
            ST_PREP: n_state = ST_RUN;
            ST_RUN:  if (w_finish) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_sp_state = r_sp_state;
        unique case (r_sp_state)
            SP_IDLE: if (r_state == ST_PREP && w_upd) n_sp_state = SP_LOAD;
            SP_LOAD: n_sp_state = SP_MUL;
            SP_MUL:  if (r_sp_cnt == 4'(MUL_DIGITS - 1)) n_sp_state = SP_SUM;
            SP_SUM:  n_sp_state = SP_COMB;
            SP_COMB: n_sp_state = SP_MAG;
            SP_MAG:  n_sp_state = SP_DIV;
            SP_DIV:  if (r_sp_cnt == 4'(DIV_DIGITS - 1)) n_sp_state = SP_SAT;
            SP_SAT:  n_sp_state = SP_PP;
            SP_PP:   n_sp_state = SP_K;
            SP_K:    if (r_sp_cnt == 4'(K_DIGITS - 1)) n_sp_state = SP_IDLE;
            default: n_sp_state = SP_IDLE;
        endcase
    end

    // Control, configuration and estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_sp_state    <= SP_IDLE;
            r_rnd_pending <= 1'b0;
            r_sp_cnt      <= '0;
            r_out_valid   <= 1'b0;
            r_cfg_offset  <= RST_POSITION_OFFSET;
            r_cfg_cpr     <= RST_COUNTS_PER_REV;
            r_cfg_pp      <= RST_POLE_PAIRS;
            r_cfg_period  <= RST_COUNTER_PERIOD;
            r_cfg_window  <= RST_SPEED_WINDOW;
            r_cfg_scale   <= RST_SPEED_SCALE;
            r_last_pos    <= '0;
            r_acc         <= '0;
            r_tick        <= '0;
            r_filtered    <= '0;
            r_held_elec   <= '0;
        end else begin
            r_state    <= n_state;
            r_sp_state <= n_sp_state;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_POSITION_OFFSET: r_cfg_offset <= i_cfg_data[RAW_W-1:0];
                    CFG_COUNTS_PER_REV:  r_cfg_cpr    <= i_cfg_data[CPR_W-1:0];
                    CFG_POLE_PAIRS:      r_cfg_pp     <= i_cfg_data[PP_W-1:0];
                    CFG_COUNTER_PERIOD:  r_cfg_period <= i_cfg_data[PERIOD_W-1:0];
                    CFG_SPEED_WINDOW:    r_cfg_window <= i_cfg_data[WINDOW_W-1:0];
                    CFG_SPEED_SCALE:     r_cfg_scale  <= i_cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == ST_PREP) begin
                r_last_pos <= r_value;
                if (w_upd) begin
                    r_acc  <= '0;
                    r_tick <= '0;
                end else begin
                    r_acc  <= w_acc_sat;
                    r_tick <= w_tick_next;
                end
            end

            if (n_sp_state != r_sp_state) begin
                r_sp_cnt <= '0;
            end else begin
                r_sp_cnt <= r_sp_cnt + 4'd1;
            end

            if (r_sp_state == SP_SAT) begin
                r_filtered <= r_num_neg ? (~w_sat_mag + 32'd1) : w_sat_mag;
            end

            // The final rounding of the electrical speed follows the last digit.
            r_rnd_pending <= (r_sp_state == SP_K) && (r_sp_cnt == 4'(K_DIGITS - 1));
            if (r_rnd_pending) begin
                r_held_elec <= r_e_neg ? (~w_e_mag + 32'd1) : w_e_mag;
            end

            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and speed datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_value <= $signed({1'b0, w_raw}) - $signed({1'b0, r_cfg_offset});
            r_down  <= i_in_data.counting_down;
        end
        if (r_state == ST_PREP) begin
            r_upd    <= w_upd;
            r_sp_acc <= w_acc_sat;
        end
        if (w_finish) begin
            r_out_data.electrical_angle <= ang_rsp.angle;
            r_out_data.speed_rpm        <= r_filtered;
            r_out_data.electrical_speed <= r_held_elec;
            r_out_data.speed_updated    <= r_upd;
        end

        case (r_sp_state)
            SP_LOAD: begin
                r_mul_m    <= r_sp_acc[31] ? (~r_sp_acc + 32'd1) : r_sp_acc;
                r_mul_neg  <= r_sp_acc[31];
                r_scale_sh <= r_cfg_scale;
                r_prod     <= '0;
            end
            SP_MUL: begin
                // The product is clamped as it grows; the clamp commutes with
                // the shift-and-add, so the final value is min(|acc|*scale, 2^40).
                r_prod     <= (w_mul_sum > 45'(PROD_CAP)) ? PROD_CAP : w_mul_sum[40:0];
                r_scale_sh <= {r_scale_sh[SCALE_W-5:0], 4'b0000};
            end
            SP_SUM: begin
                r_tp <= 43'({r_prod, 1'b0}) + 43'(r_prod);
                r_sf <= (w_f35 <<< 3) - w_f35;
            end
            SP_COMB: begin
                if (r_mul_neg) begin
                    r_num <= {{10{r_sf[34]}}, r_sf} - $signed({2'b00, r_tp});
                end else begin
                    r_num <= {{10{r_sf[34]}}, r_sf} + $signed({2'b00, r_tp});
                end
            end
            SP_MAG: begin
                // Halves round away from zero: add five to the magnitude.
                r_div_sh  <= w_num_mag + 44'd5;
                r_num_neg <= r_num[44];
                r_rem     <= '0;
                r_quo     <= '0;
            end
            SP_DIV: begin
                r_rem    <= w_div_r[3:0];
                r_quo    <= {r_quo[39:0], w_div_q};
                r_div_sh <= {r_div_sh[39:0], 4'b0000};
            end
            SP_SAT: begin
                r_e_m   <= w_sat_mag;
                r_e_neg <= r_num_neg && (w_sat_mag != '0);
            end
            SP_PP: begin
                r_e_mp   <= 39'(r_e_m) * 39'(r_cfg_pp);
                r_k_sh   <= 28'(PI30_Q28);
                r_e_prod <= '0;
            end
            SP_K: begin
                r_e_prod <= (w_k_sum > 65'(ELEC_CAP)) ? ELEC_CAP : w_k_sum[60:0];
                r_k_sh   <= {r_k_sh[23:0], 4'b0000};
            end
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

/* hdl/qase_checker.sv */
// ============================================================================
// qase_checker
// Port-level checks on the estimator, attached to the top level by bind.
// ============================================================================
`include "quadrature_angle_speed_estimator_unit_macros.svh"

module qase_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input qase_pkg::t_out_item o_out_data
);
    import qase_pkg::*;

    `QASE_ASSERT_NEXT(a_out_valid_held, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result withdrawn while stalled")
    `QASE_ASSERT_NEXT(a_out_data_held, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data), "stalled result changed")
    `QASE_ASSERT_NEXT(a_one_tick_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "second tick taken while one is in flight")
    `QASE_ASSERT_SAME(a_zero_speed, i_clk, i_rst_n, o_out_valid && o_out_data.speed_rpm == 32'sd0, o_out_data.electrical_speed == 32'sd0, "electrical speed without rpm")
    `QASE_ASSERT_SAME(a_speed_sign, i_clk, i_rst_n, o_out_valid && o_out_data.speed_rpm[31], o_out_data.electrical_speed[31] || o_out_data.electrical_speed == 32'sd0, "electrical speed sign differs from rpm")

endmodule

bind quadrature_angle_speed_estimator_unit qase_checker u_qase_checker (.*);

/* sim/quadrature_angle_speed_estimator_unit_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// quadrature_angle_speed_estimator_unit_tb
// Self-checking bench for the encoder angle and speed estimator. A short
// stimulus table covers reset values, counter extremes, negative wrap and the
// zero-valued register cases. Random phases follow, each with fresh register
// settings and mostly well-formed shaft motion. Each result transfer is checked
// against its typed table value if it has one, else a bit-accurate estimate.
// ============================================================================
module quadrature_angle_speed_estimator_unit_tb;
    import qase_pkg::*;

    typedef longint unsigned u64_t;
    typedef enum logic {ROW_CFG, ROW_TICK} row_kind_e;

    typedef struct packed {
        row_kind_e                kind;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_DATA_W-1:0]    data;
        t_in_item                 tick;
        logic                     typed;
        t_out_item                exp;
    } stim_row_t;

    localparam longint I32_MAX   = 64'sd2147483647;
    localparam longint I32_MIN   = -64'sd2147483648;
    localparam longint RAW_CLAMP = 64'sd1099511627776;
    // Angle zero, both speeds zero, no window closed.
    localparam t_out_item AT_REST = '0;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  o_cfg_ready;

    quadrature_angle_speed_estimator_unit #(
        .COUNT_BITS(16)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Register copy and estimator state
    logic [RAW_W-1:0]    cfg_offset = RST_POSITION_OFFSET;
    logic [CPR_W-1:0]    cfg_cpr    = RST_COUNTS_PER_REV;
    logic [PP_W-1:0]     cfg_pp     = RST_POLE_PAIRS;
    logic [PERIOD_W-1:0] cfg_period = RST_COUNTER_PERIOD;
    logic [WINDOW_W-1:0] cfg_window = RST_SPEED_WINDOW;
    logic [SCALE_W-1:0]  cfg_scale  = RST_SPEED_SCALE;

    longint est_last  = 0;
    longint est_acc   = 0;
    longint est_rpm   = 0;
    longint est_es    = 0;
    int     est_ticks = 0;

    t_out_item expected_results[$];
    int errors         = 0;
    int ticks_sent     = 0;
    int results_seen   = 0;
    int windows_closed = 0;
    int reg_writes     = 0;
    bit src_idle_on    = 1'b1;
    bit sink_idle_on   = 1'b1;
    int stall_left     = 0;

    function automatic longint clamp32(input longint v);
        if (v > I32_MAX) return I32_MAX;
        if (v < I32_MIN) return I32_MIN;
        return v;
    endfunction

    // Division by ten, rounding half away from zero.
    function automatic longint round_div10(input longint v);
        if (v >= 0) return (v + 5) / 10;
        return -((-v + 5) / 10);
    endfunction

    function automatic longint rpm_to_elec(input longint rpm);
        u64_t mag, prod, q;
        mag  = (rpm < 0) ? u64_t'(-rpm) : u64_t'(rpm);
        prod = mag * u64_t'(cfg_pp) * u64_t'(PI30_Q28);
        q    = (prod + (u64_t'(1) << 27)) >> 28;
        if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
        return clamp32((rpm < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic t_out_item estimate_tick(input t_in_item it);
        t_out_item r;
        longint    value, pos, delta, scaled, cpr;
        u64_t      ang;
        value = longint'(it.raw_count) - longint'(cfg_offset);
        cpr   = longint'(cfg_cpr);
        pos   = 0;
        ang   = 0;
        if (cpr != 0) begin
            // Remainder truncates towards zero, so fold negatives back in.
            pos = value % cpr;
            if (pos < 0) pos += cpr;
            ang = (u64_t'(pos) * u64_t'(cfg_pp) * 64'd65536) / u64_t'(cfg_cpr);
        end
        est_ticks = (est_ticks + 1) & 255;
        delta = value - est_last;
        if (!it.counting_down) begin
            if (value < est_last) delta += longint'(cfg_period);
        end else if (value > est_last) begin
            delta -= longint'(cfg_period);
        end
        est_acc = clamp32(est_acc + delta);
        r.speed_updated = 1'b0;
        if (est_ticks >= int'(cfg_window)) begin
            scaled = est_acc * longint'(cfg_scale);
            if (scaled > RAW_CLAMP) scaled = RAW_CLAMP;
            if (scaled < -RAW_CLAMP) scaled = -RAW_CLAMP;
            est_rpm   = clamp32(round_div10(7 * est_rpm + 3 * scaled));
            est_es    = rpm_to_elec(est_rpm);
            est_acc   = 0;
            est_ticks = 0;
            r.speed_updated = 1'b1;
        end
        est_last = value;
        r.electrical_angle = ang[ANGLE_W-1:0];
        r.speed_rpm        = est_rpm[SPEED_W-1:0];
        r.electrical_speed = est_es[SPEED_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    function automatic stim_row_t tick_row(input logic [RAW_W-1:0] raw, input logic down);
        stim_row_t row;
        row                    = '0;
        row.kind               = ROW_TICK;
        row.tick.raw_count     = raw;
        row.tick.counting_down = down;
        return row;
    endfunction

    function automatic stim_row_t checked_row(input logic [RAW_W-1:0] raw, input logic down,
                                              input t_out_item exp);
        stim_row_t row;
        row       = tick_row(raw, down);
        row.typed = 1'b1;
        row.exp   = exp;
        return row;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_POSITION_OFFSET: cfg_offset = data[RAW_W-1:0];
            CFG_COUNTS_PER_REV:  cfg_cpr    = data[CPR_W-1:0];
            CFG_POLE_PAIRS:      cfg_pp     = data[PP_W-1:0];
            CFG_COUNTER_PERIOD:  cfg_period = data[PERIOD_W-1:0];
            CFG_SPEED_WINDOW:    cfg_window = data[WINDOW_W-1:0];
            CFG_SPEED_SCALE:     cfg_scale  = data[SCALE_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic cfg_release();
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Holds the input channel quiet until every outstanding result has arrived.
    task automatic drain_results(input int settle);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic send_tick(input t_in_item it, input logic use_typed, input t_out_item typed);
        int        gap;
        t_out_item est;
        gap = 0;
        if (src_idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 18);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = it;
        do @(posedge i_clk); while (o_in_stall);
        est = estimate_tick(it);
        expected_results.push_back(use_typed ? typed : est);
        ticks_sent++;
    endtask

    // Receiver back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n || !sink_idle_on) begin
            stall_left  = 0;
            i_out_stall = 1'b0;
        end else begin
            if (stall_left == 0 && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 18);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_out_data.speed_updated === 1'b1) windows_closed++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result transfer with nothing expected: angle=%0d rpm=%0d es=%0d upd=%0b",
                         $time, o_out_data.electrical_angle, o_out_data.speed_rpm,
                         o_out_data.electrical_speed, o_out_data.speed_updated);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data !== want) begin
                    errors++;
                    $display("%0t: mismatch expected angle=%0d rpm=%0d es=%0d upd=%0b",
                             $time, want.electrical_angle, want.speed_rpm,
                             want.electrical_speed, want.speed_updated);
                    $display("%0t:          actual   angle=%0d rpm=%0d es=%0d upd=%0b",
                             $time, o_out_data.electrical_angle, o_out_data.speed_rpm,
                             o_out_data.electrical_speed, o_out_data.speed_updated);
                end
            end
        end
    end

    initial begin : watchdog
        #15_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        stim_row_t rows[$];
        t_in_item  it;
        logic      cfg_open;
        int        ph, n, k, per, lim, cnt, step;
        logic [CFG_DATA_W-1:0] v;

        // Defaults first, then negative wrap with a saturating scale, then every
        // register but the offset at zero, then the upper extremes.
        rows.push_back(checked_row(16'd0, 1'b0, AT_REST));
        rows.push_back(checked_row(16'd1000, 1'b0, AT_REST)); // exactly one electrical turn
        rows.push_back(tick_row(16'd65535, 1'b0));
        rows.push_back(tick_row(16'd0, 1'b0));
        rows.push_back(tick_row(16'd65535, 1'b1));
        rows.push_back(tick_row(16'd100, 1'b0));
        rows.push_back(tick_row(16'd200, 1'b0));
        rows.push_back(tick_row(16'd300, 1'b0));
        rows.push_back(tick_row(16'd400, 1'b0));
        rows.push_back(tick_row(16'd500, 1'b0));
        rows.push_back(cfg_row(CFG_SPEED_WINDOW, 32'd1));
        rows.push_back(cfg_row(CFG_SPEED_SCALE, 32'hFFFF_FFFF));
        rows.push_back(cfg_row(CFG_POSITION_OFFSET, 32'd65535));
        rows.push_back(tick_row(16'd0, 1'b0));
        rows.push_back(tick_row(16'd65535, 1'b1));
        rows.push_back(tick_row(16'd32768, 1'b0));
        rows.push_back(cfg_row(CFG_COUNTS_PER_REV, 32'd0));
        rows.push_back(cfg_row(CFG_POLE_PAIRS, 32'd0));
        rows.push_back(cfg_row(CFG_SPEED_WINDOW, 32'd0));
        rows.push_back(cfg_row(CFG_COUNTER_PERIOD, 32'd0));
        rows.push_back(cfg_row(CFG_SPEED_SCALE, 32'd0));
        rows.push_back(tick_row(16'd7, 1'b0));
        rows.push_back(tick_row(16'd9, 1'b1));
        rows.push_back(tick_row(16'd3, 1'b0));
        rows.push_back(cfg_row(CFG_POSITION_OFFSET, 32'd0));
        rows.push_back(cfg_row(CFG_COUNTS_PER_REV, 32'd1));
        rows.push_back(cfg_row(CFG_POLE_PAIRS, 32'd64));
        rows.push_back(cfg_row(CFG_COUNTER_PERIOD, 32'd65535));
        rows.push_back(cfg_row(CFG_SPEED_WINDOW, 32'd255));
        rows.push_back(cfg_row(CFG_SPEED_SCALE, 32'd1));
        rows.push_back(tick_row(16'd65535, 1'b0));
        rows.push_back(tick_row(16'd0, 1'b0));
        rows.push_back(tick_row(16'd1, 1'b1));
        rows.push_back(cfg_row(CFG_COUNTS_PER_REV, 32'd65535));
        rows.push_back(cfg_row(CFG_POLE_PAIRS, 32'd127));
        rows.push_back(cfg_row(CFG_SPEED_WINDOW, 32'd2));
        rows.push_back(cfg_row(CFG_SPEED_SCALE, 32'd1966080));
        rows.push_back(cfg_row(CFG_COUNTER_PERIOD, 32'd64000));
        rows.push_back(tick_row(16'd65534, 1'b0));
        rows.push_back(tick_row(16'd2, 1'b0));
        rows.push_back(tick_row(16'd40000, 1'b1));
        rows.push_back(tick_row(16'd12345, 1'b1));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        cfg_open = 1'b0;
        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                if (!cfg_open) drain_results(2);
                write_reg(rows[r].idx, rows[r].data);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) cfg_release();
                cfg_open = 1'b0;
                send_tick(rows[r].tick, rows[r].typed, rows[r].exp);
            end
        end

        for (ph = 0; ph < 12; ph++) begin
            drain_results(2);
            // The closing phase runs with neither side idling.
            src_idle_on  = (ph != 11) && ($urandom_range(0, 3) != 0);
            sink_idle_on = (ph != 11) && ($urandom_range(0, 3) != 0);

            write_reg(CFG_POSITION_OFFSET, $urandom_range(0, 65535));
            case ($urandom_range(0, 9))
                0:       v = 32'd0;
                1:       v = 32'd1;
                2:       v = 32'd65535;
                3, 4:    v = $urandom_range(0, 65535);
                default: v = $urandom_range(256, 8192);
            endcase
            write_reg(CFG_COUNTS_PER_REV, v);
            case ($urandom_range(0, 9))
                0:       v = 32'd0;
                1:       v = 32'd127;
                2:       v = $urandom_range(65, 127);
                default: v = $urandom_range(1, 64);
            endcase
            write_reg(CFG_POLE_PAIRS, v);
            case ($urandom_range(0, 9))
                0:       v = 32'd0;
                1:       v = 32'd65535;
                2:       v = 32'd64000;
                3:       v = $urandom_range(1, 1000);
                default: v = $urandom_range(1000, 65535);
            endcase
            write_reg(CFG_COUNTER_PERIOD, v);
            case ($urandom_range(0, 9))
                0:       v = 32'd0;
                1:       v = 32'd255;
                default: v = $urandom_range(1, 24);
            endcase
            write_reg(CFG_SPEED_WINDOW, v);
            case ($urandom_range(0, 5))
                0:       v = $urandom();
                1:       v = 32'd0;
                default: v = $urandom_range(0, 4000000);
            endcase
            write_reg(CFG_SPEED_SCALE, v);
            cfg_release();

            // The shaft model wraps at the counter period, a zero period being
            // treated as the full 16-bit counter.
            per  = (cfg_period == 0) ? 65536 : int'(cfg_period);
            lim  = (per > 600) ? 300 : per - 1;
            cnt  = $urandom_range(0, per - 1);
            step = int'($urandom_range(0, 2 * lim)) - lim;
            n    = (ph == 11) ? 150 : $urandom_range(85, 115);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 19) == 0) step = int'($urandom_range(0, 2 * lim)) - lim;
                if ($urandom_range(0, 49) == 0)
                    step = int'($urandom_range(0, 2 * (per - 1))) - (per - 1);
                if ($urandom_range(0, 6) == 0) begin
                    it.raw_count     = $urandom();
                    it.counting_down = $urandom_range(0, 1);
                end else begin
                    cnt += step;
                    if (cnt < 0) cnt += per;
                    else if (cnt >= per) cnt -= per;
                    it.raw_count     = cnt[RAW_W-1:0];
                    it.counting_down = (step < 0);
                end
                if (ph == 5 && k == 40) drain_results(0);
                send_tick(it, 1'b0, AT_REST);
            end
        end

        drain_results(0);
        repeat (80) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            errors += expected_results.size();
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
        end
        $display("Run covered %0d ticks over 12 random register settings and the directed table,",
                 ticks_sent);
        $display("with %0d results checked, %0d speed windows closed and %0d register writes.",
                 results_seen, windows_closed, reg_writes);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
